@@ hdl/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants, state encoding and controller/datapath interface types
// for the least-frequently-used cache table.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int KEY_W       = 32;
	localparam int DATA_W      = 32;
	localparam int USE_W       = 32;
	localparam int CAP_W       = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic OP_GET = 1'b0;
	localparam logic OP_SET = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIND,
		ST_DECIDE,
		ST_TOUCH,
		ST_APPLY,
		ST_EVCHK,
		ST_EVICT,
		ST_SLOT,
		ST_INSERT,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic find;
		logic touch;
		logic apply;
		logic evict;
		logic slot;
		logic insert;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic hit;
		logic is_set;
		logic need_evict;
		logic out_valid;
	} sts_t;

endpackage

`default_nettype wire

@@ hdl/lfu_ctrl.sv @@
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer for the cache table: steps the datapath through lookup, count
// bump, eviction and insertion walks, and hands off results.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_ctrl import lfu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_FIND;
				end
			end
			ST_FIND: begin
				cmd.find = 1'b1;
				if (sts.last) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.clear = 1'b1;
				if (sts.hit) begin
					state_d = ST_TOUCH;
				end else if (sts.is_set) begin
					state_d = ST_EVCHK;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_TOUCH: begin
				cmd.touch = 1'b1;
				if (sts.last) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = sts.is_set ? ST_IDLE : ST_RESULT;
			end
			ST_EVCHK: begin
				cmd.clear = 1'b1;
				state_d   = sts.need_evict ? ST_EVICT : ST_SLOT;
			end
			ST_EVICT: begin
				cmd.evict = 1'b1;
				if (sts.last) begin
					state_d = ST_EVCHK;
				end
			end
			ST_SLOT: begin
				cmd.slot = 1'b1;
				if (sts.last) begin
					state_d = ST_INSERT;
				end
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_RESULT: begin
				if (!sts.out_valid || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/lfu_dp.sv @@
// ----------------------------------------------------------------------------
// lfu_dp
// Entry storage, walk counter, capacity register and output register of the
// cache table; performs one walk step per cycle on command.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_dp import lfu_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	output sts_t                   sts,
	input  wire logic              in_op,
	input  wire logic [KEY_W-1:0]  in_key,
	input  wire logic [DATA_W-1:0] in_value,
	input  wire logic              cfg_we,
	input  wire logic [CAP_W-1:0]  cfg_cap,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output logic                   out_hit,
	output logic [DATA_W-1:0]      out_value
);

	logic [MAX_ENTRIES-1:0] valid_q;
	logic [KEY_W-1:0]       key_q   [MAX_ENTRIES];
	logic [DATA_W-1:0]      data_q  [MAX_ENTRIES];
	logic [USE_W-1:0]       uses_q  [MAX_ENTRIES];
	logic [IDX_W-1:0]       rank_q  [MAX_ENTRIES];
	logic [CNT_W-1:0]       occ_q;
	logic [CAP_W-1:0]       cap_q;

	logic                   op_q;
	logic [KEY_W-1:0]       in_key_q;
	logic [DATA_W-1:0]      in_value_q;

	logic [IDX_W-1:0]       idx_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   flag_q;
	logic                   hit_q;
	logic [IDX_W-1:0]       slot_q;
	logic [DATA_W-1:0]      hit_data_q;
	logic [USE_W-1:0]       uses_new_q;
	logic [IDX_W-1:0]       hit_rank_q;

	logic                   out_valid_q;
	logic                   out_hit_q;
	logic [DATA_W-1:0]      out_value_q;

	logic                   last;
	logic [CNT_W-1:0]       eff_cap;
	logic                   cur_valid;
	logic [KEY_W-1:0]       cur_key;
	logic [USE_W-1:0]       cur_uses;
	logic [IDX_W-1:0]       cur_rank;

	assign last      = (idx_q == IDX_W'(MAX_ENTRIES - 1));
	assign cur_valid = valid_q[idx_q];
	assign cur_key   = key_q[idx_q];
	assign cur_uses  = uses_q[idx_q];
	assign cur_rank  = rank_q[idx_q];

	// zero reads as one, anything past the table size clamps to it
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CNT_W'(1);
		end else if (32'(cap_q) > 32'(MAX_ENTRIES)) begin
			eff_cap = CNT_W'(MAX_ENTRIES);
		end else begin
			eff_cap = CNT_W'(cap_q);
		end
	end

	assign sts.last       = last;
	assign sts.hit        = hit_q;
	assign sts.is_set     = (op_q == OP_SET);
	assign sts.need_evict = (occ_q >= eff_cap) && (occ_q != '0);
	assign sts.out_valid  = out_valid_q;

	assign out_valid = out_valid_q;
	assign out_hit   = out_hit_q;
	assign out_value = out_value_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			occ_q       <= '0;
			cap_q       <= CAP_RESET;
			idx_q       <= '0;
			cnt_q       <= '0;
			flag_q      <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_cap;
			end
			if (cmd.load || cmd.clear) begin
				idx_q  <= '0;
				cnt_q  <= '0;
				flag_q <= 1'b0;
			end else if (cmd.find || cmd.touch || cmd.evict || cmd.slot) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.load) begin
				hit_q <= 1'b0;
			end
			if (cmd.find && cur_valid && (cur_key == in_key_q) && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (cmd.touch && (idx_q != slot_q) && cur_valid && (cur_rank < hit_rank_q)
					&& (cur_uses > uses_new_q)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.evict) begin
				if (cur_valid && (CNT_W'(cur_rank) == occ_q - CNT_W'(1)) && !flag_q) begin
					valid_q[idx_q] <= 1'b0;
					flag_q         <= 1'b1;
				end
				if (last) begin
					occ_q <= occ_q - CNT_W'(1);
				end
			end
			if (cmd.slot) begin
				if (cur_valid) begin
					if (cur_uses != '0) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end else if (!flag_q) begin
					flag_q <= 1'b1;
				end
			end
			if (cmd.insert && flag_q) begin
				valid_q[slot_q] <= 1'b1;
				occ_q           <= occ_q + CNT_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= in_op;
			in_key_q   <= in_key;
			in_value_q <= in_value;
		end
		if (cmd.find && cur_valid && (cur_key == in_key_q) && !hit_q) begin
			slot_q     <= idx_q;
			hit_data_q <= data_q[idx_q];
			uses_new_q <= (cur_uses == '1) ? cur_uses : cur_uses + USE_W'(1);
			hit_rank_q <= cur_rank;
		end
		if (cmd.slot && !cur_valid && !flag_q) begin
			slot_q <= idx_q;
		end
		if (cmd.apply) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if ((IDX_W'(i) != slot_q) && valid_q[i]
						&& (CNT_W'(rank_q[i]) >= cnt_q) && (rank_q[i] < hit_rank_q)) begin
					rank_q[i] <= rank_q[i] + IDX_W'(1);
				end
			end
			rank_q[slot_q] <= IDX_W'(cnt_q);
			uses_q[slot_q] <= uses_new_q;
			if (op_q == OP_SET) begin
				data_q[slot_q] <= in_value_q;
			end
		end
		if (cmd.insert && flag_q) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (valid_q[i] && (CNT_W'(rank_q[i]) >= cnt_q)) begin
					rank_q[i] <= rank_q[i] + IDX_W'(1);
				end
			end
			rank_q[slot_q] <= IDX_W'(cnt_q);
			key_q[slot_q]  <= in_key_q;
			data_q[slot_q] <= in_value_q;
			uses_q[slot_q] <= '0;
		end
		if (cmd.emit) begin
			out_hit_q   <= hit_q;
			out_value_q <= hit_q ? hit_data_q : '1;
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(occ_q) <= 32'(MAX_ENTRIES))
		else $error("occupancy beyond table size");

	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.evict |-> ($countones(valid_q) == 32'(occ_q)))
		else $error("occupancy out of step with valid entries");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.insert && flag_q) |=> (occ_q == $past(occ_q) + CNT_W'(1)))
		else $error("insert did not add an entry");

	a_evict_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.evict && last) |=> (occ_q == $past(occ_q) - CNT_W'(1)))
		else $error("eviction walk did not remove an entry");

endmodule

`default_nettype wire

@@ hdl/lfu_cache_table_unit.sv @@
// ----------------------------------------------------------------------------
// lfu_cache_table_unit
// Key-value cache table with least-frequently-used replacement.
// ----------------------------------------------------------------------------
// Input words arrive on s_axis: tuser is the operation (get or set), tdata
// holds the key and the value. A get yields one word on m_axis (tuser = hit,
// tdata = stored value or all ones on a miss); a set yields nothing.
// The capacity register is written through cfg_valid/cfg_data; the user
// must write it only while idle, as the block does not enforce this. One
// word is processed at a time. Every item walks all 16 entries once to
// look up its key. A hit then walks them again to re-rank the bumped entry.
// A set on a new key walks them once for each entry evicted and once more
// to find a free slot. The result sits in an output register, so a new
// word is accepted while it waits; if the receiver stalls, the next get
// waits in its result state until that register frees. Reset empties the
// table and sets capacity to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cache_table_unit import lfu_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [KEY_W+DATA_W-1:0] s_axis_tdata,  // key, value
	input  wire logic                   s_axis_tuser,  // operation
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [DATA_W-1:0]           m_axis_tdata,  // read_value
	output logic                        m_axis_tuser,  // hit
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CAP_W-1:0]       cfg_data       // capacity_in_use
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	lfu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_ready(m_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lfu_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_op    (s_axis_tuser),
		.in_key   (s_axis_tdata[KEY_W-1:0]),
		.in_value (s_axis_tdata[KEY_W+DATA_W-1:KEY_W]),
		.cfg_we   (cfg_valid),
		.cfg_cap  (cfg_data),
		.out_ready(m_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_hit  (m_axis_tuser),
		.out_value(m_axis_tdata)
	);

endmodule

`default_nettype wire

@@ sim/lfu_cache_checker.sv @@
// ----------------------------------------------------------------------------
// lfu_cache_checker
// Watches the request, response and capacity channels of the LFU cache
// table, keeps its own copy of the table with use counts and victim order,
// and compares every response word against the predicted hit flag and value.
// ----------------------------------------------------------------------------
module lfu_cache_checker import lfu_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	input  logic                     s_axis_tready,
	input  logic [KEY_W+DATA_W-1:0]  s_axis_tdata,   // key, value
	input  logic                     s_axis_tuser,   // operation
	input  logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	input  logic [DATA_W-1:0]        m_axis_tdata,   // read_value
	input  logic                     m_axis_tuser,   // hit
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CAP_W-1:0]         cfg_data,       // capacity_in_use
	output int                       mismatches,
	output int                       reads_open
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		logic              hit;
		logic [DATA_W-1:0] value;
	} read_word_t;

	read_word_t reads_due[$];

	logic              slot_used [MAX_ENTRIES];
	logic [KEY_W-1:0]  slot_key  [MAX_ENTRIES];
	logic [DATA_W-1:0] slot_data [MAX_ENTRIES];
	logic [USE_W-1:0]  slot_uses [MAX_ENTRIES];
	logic [IDX_W-1:0]  slot_order[MAX_ENTRIES];
	logic [CNT_W-1:0]  fill;
	logic [CAP_W-1:0]  capacity;

	task automatic report(input string what, input logic [DATA_W-1:0] got,
		input logic [DATA_W-1:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("%0t lfu check: %s got %h expected %h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic clear_table();
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			slot_used[i]  = 1'b0;
			slot_key[i]   = '0;
			slot_data[i]  = '0;
			slot_uses[i]  = '0;
			slot_order[i] = '0;
		end
		fill     = '0;
		capacity = CAP_RESET;
		reads_due.delete();
	endtask

	function automatic int locate(input logic [KEY_W-1:0] k);
		for (int i = 0; i < MAX_ENTRIES; i++)
			if (slot_used[i] && slot_key[i] == k) return i;
		return -1;
	endfunction

	// count up (saturating) and move ahead of every entry not above the new count
	task automatic bump(input int s);
		logic [USE_W-1:0] u;
		int               r;
		int               nr;
		u  = slot_uses[s];
		r  = slot_order[s];
		nr = 0;
		if (u != '1) u++;
		slot_uses[s] = u;
		for (int i = 0; i < MAX_ENTRIES; i++)
			if (i != s && slot_used[i] && slot_order[i] < r && slot_uses[i] > u) nr++;
		for (int i = 0; i < MAX_ENTRIES; i++)
			if (i != s && slot_used[i] && slot_order[i] >= nr && slot_order[i] < r)
				slot_order[i]++;
		slot_order[s] = IDX_W'(nr);
	endtask

	task automatic drop_victim();
		if (fill == 0) return;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (slot_used[i] && slot_order[i] == fill - 1) begin
				slot_used[i] = 1'b0;
				break;
			end
		end
		fill--;
	endtask

	task automatic admit(input logic [KEY_W-1:0] k, input logic [DATA_W-1:0] v);
		int lim;
		int nr;
		int spare;
		lim   = (capacity == 0) ? 1 : ((capacity > MAX_ENTRIES) ? MAX_ENTRIES : capacity);
		nr    = 0;
		spare = -1;
		while (fill >= lim && fill > 0) drop_victim();
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (slot_used[i]) begin
				if (slot_uses[i] > 0) nr++;
			end else if (spare < 0) begin
				spare = i;
			end
		end
		if (spare < 0) return;
		for (int i = 0; i < MAX_ENTRIES; i++)
			if (slot_used[i] && slot_order[i] >= nr) slot_order[i]++;
		slot_used[spare]  = 1'b1;
		slot_key[spare]   = k;
		slot_data[spare]  = v;
		slot_uses[spare]  = '0;
		slot_order[spare] = IDX_W'(nr);
		fill++;
	endtask

	task automatic serve(input logic op, input logic [KEY_W-1:0] k,
		input logic [DATA_W-1:0] v, output read_word_t res);
		int s;
		s   = locate(k);
		res = '{hit: 1'b0, value: '1};
		if (op == OP_GET) begin
			if (s >= 0) begin
				bump(s);
				res = '{hit: 1'b1, value: slot_data[s]};
			end
		end else if (s >= 0) begin
			slot_data[s] = v;
			bump(s);
		end else begin
			admit(k, v);
		end
	endtask

	initial begin
		mismatches = 0;
		reads_open = 0;
		clear_table();
	end

	always @(posedge clk or negedge arst_n) begin
		read_word_t want;
		read_word_t res;
		if (!arst_n) begin
			clear_table();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (reads_due.size() == 0) begin
					report("unexpected word", m_axis_tdata, '1);
				end else begin
					want = reads_due.pop_front();
					if (m_axis_tuser !== want.hit)
						report("hit", DATA_W'(m_axis_tuser), DATA_W'(want.hit));
					if (m_axis_tdata !== want.value)
						report("read_value", m_axis_tdata, want.value);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				serve(s_axis_tuser, s_axis_tdata[KEY_W-1:0],
					s_axis_tdata[KEY_W +: DATA_W], res);
				if (s_axis_tuser == OP_GET) reads_due = {reads_due, res};
			end
			if (cfg_valid && cfg_ready) capacity = cfg_data;
		end
		reads_open = reads_due.size();
	end

endmodule

@@ sim/lfu_cache_table_unit_tb.sv @@
// ----------------------------------------------------------------------------
// lfu_cache_table_unit_tb
// Drives get and set words into the LFU cache table under bursty input and a
// stalling receiver, moves the capacity through its extremes between phases,
// and lets the checker compare every response with its own table model.
// ----------------------------------------------------------------------------
module lfu_cache_table_unit_tb import lfu_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES  = 350;
	localparam int HOLD_CYCLES    = 500;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_WORDS    = 50;
	localparam int POOL_SIZE      = 32;

	typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_mode_t;

	logic                    clk;
	logic                    arst_n;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [KEY_W+DATA_W-1:0] s_axis_tdata;   // key, value
	logic                    s_axis_tuser;   // operation
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	logic [DATA_W-1:0]       m_axis_tdata;   // read_value
	logic                    m_axis_tuser;   // hit
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CAP_W-1:0]        cfg_data;       // capacity_in_use

	int mismatches;
	int reads_open;
	int burst_left;
	int gap_top;
	int idle_cycles;
	bit hold_now;

	logic [KEY_W-1:0] key_pool[POOL_SIZE];

	lfu_cache_table_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	lfu_cache_checker lfu_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.reads_open    (reads_open)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: changing stall patterns plus one long hold-off
	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       hold_left;
		m_axis_tready = 1'b0;
		mode          = RX_OPEN;
		mode_left     = 0;
		hold_left     = HOLD_CYCLES;
		forever begin
			@(posedge clk);
			if (hold_now && hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					RX_OPEN:   m_axis_tready <= 1'b1;
					RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
					RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 7) != 0);
					default:   m_axis_tready <= ($urandom_range(0, 5) == 0);
				endcase
			end
		end
	end

	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready) || !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("lfu_cache_table_unit_tb: errors");
				$finish;
			end
		end
	end

	// burst pacing happens before the word goes out, so tvalid only drops between bursts or while settling
	task automatic issue(input logic op, input logic [KEY_W-1:0] k,
		input logic [DATA_W-1:0] v);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, gap_top)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
			gap_top    = ($urandom_range(0, 2) == 0) ? 40 : 3;
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {v, k};
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (reads_open != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] c);
		cfg_valid <= 1'b1;
		cfg_data  <= c;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// skewed toward the low pool entries so use counts spread apart
	function automatic logic [KEY_W-1:0] pick_key(input int span);
		if ($urandom_range(0, 9) == 0) return $urandom;
		return key_pool[$urandom_range(0, $urandom_range(1, span - 1))];
	endfunction

	task automatic random_phase(input int words, input int span);
		logic op;
		for (int n = 0; n < words; n++) begin
			op = ($urandom_range(0, 1) == 0) ? OP_GET : OP_SET;
			issue(op, pick_key(span), $urandom);
		end
	endtask

	initial begin
		logic [CAP_W-1:0] caps[9];
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_GET;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		hold_now      = 1'b0;
		burst_left    = 8;
		gap_top       = 3;
		key_pool[0]   = '0;
		key_pool[1]   = '1;
		for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
		caps = '{5'd31, 5'd1, 5'd16, 5'd8, 5'd0, 5'd17, 5'($urandom_range(0, 31)),
			5'd2, 5'd16};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_capacity(5'd4);
		issue(OP_GET, 32'h0000_0000, 32'h1234_5678);
		issue(OP_SET, 32'h0000_0000, 32'h8000_0000);
		issue(OP_SET, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		issue(OP_GET, 32'h0000_0000, 32'h0000_0000);
		issue(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue(OP_SET, 32'h0000_0000, 32'hFFFF_FFFF);
		issue(OP_GET, 32'h0000_0000, 32'h0000_0000);
		issue(OP_SET, 32'h0000_0001, 32'h0000_0011);
		issue(OP_SET, 32'h0000_0002, 32'h0000_0022);
		// full table: oldest zero-count key goes
		issue(OP_SET, 32'h0000_0003, 32'h0000_0033);
		issue(OP_GET, 32'h0000_0001, 32'h0000_0000);
		issue(OP_GET, 32'h0000_0002, 32'h0000_0000);
		settle();

		// capacity below occupancy
		write_capacity(5'd2);
		issue(OP_SET, 32'h0000_0004, 32'h0000_0044);
		issue(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		issue(OP_GET, 32'h0000_0000, 32'h0000_0000);
		settle();

		// zero capacity holds one entry
		write_capacity(5'd0);
		issue(OP_SET, 32'h0000_0005, 32'h0000_0055);
		issue(OP_GET, 32'h0000_0005, 32'h0000_0000);
		issue(OP_GET, 32'h0000_0000, 32'h0000_0000);
		settle();

		foreach (caps[p]) begin
			write_capacity(caps[p]);
			if (p == 2) hold_now = 1'b1;
			random_phase(PHASE_WORDS, (caps[p] < 3) ? 4 : 24);
			settle();
		end

		if (mismatches == 0)
			$display("lfu_cache_table_unit_tb: clean");
		else
			$display("lfu_cache_table_unit_tb: errors");
		$finish;
	end

endmodule
